### rtl/mvfd_pkg.sv
// ----------------------------------------------------------------------------
// mvfd_pkg
// Shared types, constants and the CRC-16/X25 byte update for the MAVLink v1
// flow / distance frame parser.
// ----------------------------------------------------------------------------
package mvfd_pkg;

	localparam logic [7:0]  START_MARK   = 8'hFE;
	localparam logic [15:0] CRC_INIT     = 16'hFFFF;
	localparam logic [15:0] CRC_POLY     = 16'h8408;
	localparam logic [7:0]  ID_FLOW      = 8'd100;
	localparam logic [7:0]  ID_DIST      = 8'd132;
	localparam logic [7:0]  EXTRA_FLOW   = 8'd175;
	localparam logic [7:0]  EXTRA_DIST   = 8'd85;
	localparam logic [7:0]  MIN_LEN_FLOW = 8'd26;
	localparam logic [7:0]  MIN_LEN_DIST = 8'd10;

	localparam logic KIND_FLOW = 1'b0;
	localparam logic KIND_DIST = 1'b1;

	// One result, lowest field last in the declaration.
	typedef struct packed {
		logic [15:0] distance_cm;
		logic [7:0]  flow_quality;
		logic [15:0] flow_y;
		logic [15:0] flow_x;
		logic        fields_updated;
		logic        message_kind;
	} mvfd_result_t;

	// Reflected CRC-16/X25 update for one byte, no final xor.
	function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

### rtl/mvfd_parser.sv
// ----------------------------------------------------------------------------
// mvfd_parser
// Frame state machine: header walk, payload capture, CRC check and the
// flow / distance snapshot. One byte is consumed per byte_valid cycle.
// ----------------------------------------------------------------------------
module mvfd_parser import mvfd_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         byte_valid,
	input  logic [7:0]   rx_byte,
	output logic         res_valid,
	output mvfd_result_t res
);

	localparam logic [3:0] PH_WAIT    = 4'd0;
	localparam logic [3:0] PH_LEN     = 4'd1;
	localparam logic [3:0] PH_SEQ     = 4'd2;
	localparam logic [3:0] PH_SYS     = 4'd3;
	localparam logic [3:0] PH_COMP    = 4'd4;
	localparam logic [3:0] PH_MSGID   = 4'd5;
	localparam logic [3:0] PH_PAYLOAD = 4'd6;
	localparam logic [3:0] PH_CRCL    = 4'd7;
	localparam logic [3:0] PH_CRCH    = 4'd8;

	logic [3:0]  phase_q, phase_d;
	logic [7:0]  len_q, len_d;
	logic [15:0] crc_q, crc_d;
	logic [7:0]  pos_q, pos_d;
	logic [7:0]  msgid_q, msgid_d;
	logic [7:0]  crcl_q, crcl_d;
	logic [7:0]  cap_q [8];
	logic [15:0] snap_fx_q, snap_fx_d;
	logic [15:0] snap_fy_q, snap_fy_d;
	logic [7:0]  snap_ql_q, snap_ql_d;
	logic [15:0] snap_dist_q, snap_dist_d;

	logic [15:0] crc_byte;
	logic [15:0] crc_extra;
	logic [7:0]  pos_inc;
	logic        is_flow;
	logic        crc_ok;
	logic        upd;

	assign crc_byte  = crc_feed(crc_q, rx_byte);
	assign is_flow   = (msgid_q == ID_FLOW);
	assign crc_extra = crc_feed(crc_q, is_flow ? EXTRA_FLOW : EXTRA_DIST);
	assign crc_ok    = (crc_extra == {rx_byte, crcl_q});
	assign pos_inc   = pos_q + 8'd1;

	always_comb begin
		phase_d     = phase_q;
		len_d       = len_q;
		crc_d       = crc_q;
		pos_d       = pos_q;
		msgid_d     = msgid_q;
		crcl_d      = crcl_q;
		snap_fx_d   = snap_fx_q;
		snap_fy_d   = snap_fy_q;
		snap_ql_d   = snap_ql_q;
		snap_dist_d = snap_dist_q;
		upd         = 1'b0;
		res_valid   = 1'b0;
		case (phase_q)
			PH_WAIT: begin
				if (rx_byte == START_MARK) begin
					phase_d = PH_LEN;
				end
			end
			PH_LEN: begin
				len_d   = rx_byte;
				pos_d   = 8'd0;
				crc_d   = crc_feed(CRC_INIT, rx_byte);
				phase_d = PH_SEQ;
			end
			PH_SEQ: begin
				crc_d   = crc_byte;
				phase_d = PH_SYS;
			end
			PH_SYS: begin
				crc_d   = crc_byte;
				phase_d = PH_COMP;
			end
			PH_COMP: begin
				crc_d   = crc_byte;
				phase_d = PH_MSGID;
			end
			PH_MSGID: begin
				msgid_d = rx_byte;
				crc_d   = crc_byte;
				if (rx_byte != ID_FLOW && rx_byte != ID_DIST) begin
					phase_d = PH_WAIT;
					pos_d   = 8'd0;
				end else if (len_q != 8'd0) begin
					phase_d = PH_PAYLOAD;
				end else begin
					phase_d = PH_CRCL;
				end
			end
			PH_PAYLOAD: begin
				crc_d = crc_byte;
				pos_d = pos_inc;
				if (pos_inc == len_q) begin
					phase_d = PH_CRCL;
				end
			end
			PH_CRCL: begin
				crcl_d  = rx_byte;
				phase_d = PH_CRCH;
			end
			PH_CRCH: begin
				crc_d = crc_extra;
				if (crc_ok) begin
					res_valid = 1'b1;
					if (is_flow) begin
						if (len_q >= MIN_LEN_FLOW) begin
							snap_fx_d = {cap_q[3], cap_q[2]};
							snap_fy_d = {cap_q[5], cap_q[4]};
							snap_ql_d = cap_q[7];
							upd       = 1'b1;
						end
					end else if (len_q >= MIN_LEN_DIST) begin
						snap_dist_d = {cap_q[1], cap_q[0]};
						upd         = 1'b1;
					end
				end
				phase_d = PH_WAIT;
				pos_d   = 8'd0;
			end
			default: begin
				phase_d = PH_WAIT;
				pos_d   = 8'd0;
			end
		endcase
		res_valid = res_valid & byte_valid;
	end

	// Result carries the snapshot as it stands after this frame.
	always_comb begin
		res.message_kind   = is_flow ? KIND_FLOW : KIND_DIST;
		res.fields_updated = upd;
		res.flow_x         = snap_fx_d;
		res.flow_y         = snap_fy_d;
		res.flow_quality   = snap_ql_d;
		res.distance_cm    = snap_dist_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_WAIT;
			len_q       <= 8'd0;
			crc_q       <= CRC_INIT;
			pos_q       <= 8'd0;
			msgid_q     <= 8'd0;
			crcl_q      <= 8'd0;
			snap_fx_q   <= 16'd0;
			snap_fy_q   <= 16'd0;
			snap_ql_q   <= 8'd0;
			snap_dist_q <= 16'd0;
		end else if (byte_valid) begin
			phase_q     <= phase_d;
			len_q       <= len_d;
			crc_q       <= crc_d;
			pos_q       <= pos_d;
			msgid_q     <= msgid_d;
			crcl_q      <= crcl_d;
			snap_fx_q   <= snap_fx_d;
			snap_fy_q   <= snap_fy_d;
			snap_ql_q   <= snap_ql_d;
			snap_dist_q <= snap_dist_d;
		end
	end

	// Kept payload bytes: 8-9 into slots 0-1, 20-25 into slots 2-7.
	always_ff @(posedge clk) begin
		if (byte_valid && phase_q == PH_PAYLOAD) begin
			if (pos_q == 8'd8) begin
				cap_q[0] <= rx_byte;
			end
			if (pos_q == 8'd9) begin
				cap_q[1] <= rx_byte;
			end
			for (int i = 0; i < 6; i++) begin
				if (pos_q == 8'(20 + i)) begin
					cap_q[i + 2] <= rx_byte;
				end
			end
		end
	end

endmodule

### rtl/mvfd_out_reg.sv
// ----------------------------------------------------------------------------
// mvfd_out_reg
// Result register on the master side; frees the slave side whenever the
// register is empty or being drained in the same cycle.
// ----------------------------------------------------------------------------
module mvfd_out_reg import mvfd_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         load,
	input  mvfd_result_t load_res,
	output logic         can_load,
	output logic         out_valid,
	input  logic         out_ready,
	output mvfd_result_t out_res
);

	logic         valid_q;
	mvfd_result_t res_q;

	assign can_load  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_res   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_load) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (can_load && load) begin
			res_q <= load_res;
		end
	end

endmodule

### rtl/mavlink_v1_flow_distance_parser_top.sv
// ----------------------------------------------------------------------------
// mavlink_v1_flow_distance_parser_top
// MAVLink v1 byte-stream parser for optical flow (id 100) and distance
// sensor (id 132) frames, CRC-16/X25 checked, with a running snapshot.
// ----------------------------------------------------------------------------
//
//  channel | dir | tdata                         | tuser                  | tlast
//  --------+-----+-------------------------------+------------------------+------
//  s_*     | in  | [7:0] rx_byte                 | -                      | -
//  m_*     | out | flow_x, flow_y, quality, dist | message_kind, updated  | -
//
//  One byte per cycle while s_tready is high: each accepted byte goes through
//  the frame state machine and the byte-wide CRC update in the cycle it is
//  accepted. A frame with a good CRC loads one result into the output
//  register on its last CRC byte; other bytes produce no result.
//  s_tready drops only while a result sits in the output register and
//  m_tready is low. Reset (arst_n low) returns to hunting for 0xFE and
//  clears the snapshot to zero.
//
module mavlink_v1_flow_distance_parser_top import mvfd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // [15:0] flow_x, [31:16] flow_y,
	                               // [39:32] flow_quality, [55:40] distance_cm
	output logic [1:0]  m_tuser    // [0] message_kind, [1] fields_updated
);

	logic         byte_take;
	logic         res_valid;
	mvfd_result_t res;
	mvfd_result_t out_res;
	logic         can_load;

	// A byte is taken whenever the output register can absorb its result.
	assign s_tready  = can_load;
	assign byte_take = s_tvalid && can_load;

	mvfd_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_take),
		.rx_byte    (s_tdata),
		.res_valid  (res_valid),
		.res        (res)
	);

	mvfd_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (res_valid),
		.load_res  (res),
		.can_load  (can_load),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (out_res)
	);

	// Stream packing, lowest field last.
	assign m_tdata = {out_res.distance_cm, out_res.flow_quality,
	                  out_res.flow_y, out_res.flow_x};
	assign m_tuser = {out_res.fields_updated, out_res.message_kind};

endmodule

### verif/mavlink_v1_flow_distance_parser_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mavlink_v1_flow_distance_parser_top_test
// Streams MAVLink v1 byte traffic into the parser: a short list of
// hand-built frames first, then random frames, noise and broken frames under
// several idle patterns and one long output hold-off. Every good-CRC frame
// is predicted here and each result is compared field by field.
// ----------------------------------------------------------------------------
module mavlink_v1_flow_distance_parser_top_test;
	import mvfd_pkg::*;

	localparam int LIMIT_CYCLES = 400000;
	localparam int HOLD_CYCLES  = 400;
	localparam int PHASE_BYTES  = 200;

	// parser phases as the prediction walks them
	typedef enum logic [3:0] {
		FP_HUNT, FP_LEN, FP_SEQ, FP_SYS, FP_COMP, FP_ID, FP_PAYLOAD, FP_CRC_LO, FP_CRC_HI
	} frame_phase_e;

	// one byte on its way in; a pinned byte carries a typed-in result
	typedef struct packed {
		logic [7:0]   data;
		logic         pinned;
		mvfd_result_t pinned_res;
	} rx_item_t;

	// one hand-built frame
	typedef struct packed {
		logic [7:0]   id;
		logic [7:0]   len;
		logic         rand_fill;   // random header and payload bytes
		logic [7:0]   fill;        // else every header and payload byte
		logic         bad_crc;
		logic         pinned;
		mvfd_result_t res;
	} frame_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;   // [7:0] rx_byte
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [55:0] m_tdata;           // [15:0] flow_x, [31:16] flow_y,
	                                // [39:32] flow_quality, [55:40] distance_cm
	logic [1:0]  m_tuser;           // [0] message_kind, [1] fields_updated

	rx_item_t     rx_bytes_q[$];
	rx_item_t     in_flight;
	mvfd_result_t results_due_q[$];
	int           errors = 0;
	int           cycles = 0;
	int           idle_pct = 0;     // sender idles this often out of 100
	int           stall_pct = 0;    // receiver stalls this often out of 100
	bit           hold_req = 1'b0;
	int           hold_left = 0;
	int           bytes_queued = 0;

	// predicted parser state
	frame_phase_e ph;
	logic [7:0]   p_len;
	logic [15:0]  p_crc;
	logic [7:0]   p_pos;
	logic [7:0]   p_id;
	logic [7:0]   p_crc_lo;
	logic [7:0]   kept[8];
	logic [15:0]  snap_fx, snap_fy, snap_dist;
	logic [7:0]   snap_q;

	mavlink_v1_flow_distance_parser_top DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #5 clk = ~clk;

	// CRC-16/X25 step, one bit at a time, LSB first
	function automatic logic [15:0] x25_update(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		logic        fb;
		c = crc;
		for (int i = 0; i < 8; i++) begin
			fb = c[0] ^ b[i];
			c = c >> 1;
			if (fb) begin
				c = c ^ CRC_POLY;
			end
		end
		return c;
	endfunction

	function automatic mvfd_result_t mk_result(input logic kind, input logic upd,
			input logic [15:0] fx, input logic [15:0] fy, input logic [7:0] q,
			input logic [15:0] distance);
		mvfd_result_t r;
		r.message_kind   = kind;
		r.fields_updated = upd;
		r.flow_x         = fx;
		r.flow_y         = fy;
		r.flow_quality   = q;
		r.distance_cm    = distance;
		return r;
	endfunction

	// Advance the predicted parser by one byte; returns 1 when a frame
	// closes with a good CRC and fills r with the snapshot it reports.
	function automatic bit parse_byte(input logic [7:0] b, output mvfd_result_t r);
		bit   got;
		bit   is_flow;
		bit   upd;
		got = 1'b0;
		r = '0;
		case (ph)
			FP_HUNT: begin
				if (b == START_MARK) ph = FP_LEN;
			end
			FP_LEN: begin
				p_len = b;
				p_pos = 8'd0;
				p_crc = x25_update(CRC_INIT, b);
				ph = FP_SEQ;
			end
			FP_SEQ: begin
				p_crc = x25_update(p_crc, b);
				ph = FP_SYS;
			end
			FP_SYS: begin
				p_crc = x25_update(p_crc, b);
				ph = FP_COMP;
			end
			FP_COMP: begin
				p_crc = x25_update(p_crc, b);
				ph = FP_ID;
			end
			FP_ID: begin
				p_id = b;
				p_crc = x25_update(p_crc, b);
				if (b != ID_FLOW && b != ID_DIST) begin
					ph = FP_HUNT;
					p_pos = 8'd0;
				end else begin
					ph = (p_len != 8'd0) ? FP_PAYLOAD : FP_CRC_LO;
				end
			end
			FP_PAYLOAD: begin
				// keep distance bytes 8-9 and flow bytes 20-25
				if (p_pos == 8'd8 || p_pos == 8'd9) kept[p_pos - 8] = b;
				else if (p_pos >= 8'd20 && p_pos <= 8'd25) kept[p_pos - 18] = b;
				p_crc = x25_update(p_crc, b);
				p_pos = p_pos + 8'd1;
				if (p_pos == p_len) ph = FP_CRC_LO;
			end
			FP_CRC_LO: begin
				p_crc_lo = b;
				ph = FP_CRC_HI;
			end
			default: begin
				is_flow = (p_id == ID_FLOW);
				p_crc = x25_update(p_crc, is_flow ? EXTRA_FLOW : EXTRA_DIST);
				if (p_crc == {b, p_crc_lo}) begin
					upd = 1'b0;
					if (is_flow && p_len >= MIN_LEN_FLOW) begin
						snap_fx = {kept[3], kept[2]};
						snap_fy = {kept[5], kept[4]};
						snap_q  = kept[7];
						upd = 1'b1;
					end else if (!is_flow && p_len >= MIN_LEN_DIST) begin
						snap_dist = {kept[1], kept[0]};
						upd = 1'b1;
					end
					r = mk_result(is_flow ? KIND_FLOW : KIND_DIST, upd,
						snap_fx, snap_fy, snap_q, snap_dist);
					got = 1'b1;
				end
				ph = FP_HUNT;
				p_pos = 8'd0;
			end
		endcase
		return got;
	endfunction

	function automatic void push_byte(input logic [7:0] v, input logic pin,
			input mvfd_result_t res);
		rx_item_t it;
		it.data = v;
		it.pinned = pin;
		it.pinned_res = res;
		rx_bytes_q.push_back(it);
		bytes_queued++;
	endfunction

	// Queue one frame. keep > 0 cuts it after that many bytes.
	function automatic void queue_frame(input logic [7:0] id, input logic [7:0] len,
			input logic rand_fill, input logic [7:0] fill, input logic bad,
			input int keep, input logic pin, input mvfd_result_t res);
		logic [7:0]  body[$];
		logic [15:0] crc;
		int          total;
		body.push_back(len);
		for (int i = 0; i < 3; i++) body.push_back(rand_fill ? 8'($urandom_range(255)) : fill);
		body.push_back(id);
		for (int i = 0; i < len; i++)
			body.push_back(rand_fill ? 8'($urandom_range(255)) : fill);
		crc = CRC_INIT;
		foreach (body[i]) crc = x25_update(crc, body[i]);
		crc = x25_update(crc, (id == ID_FLOW) ? EXTRA_FLOW : EXTRA_DIST);
		if (bad) crc = crc ^ (16'h0001 << $urandom_range(15));
		body.push_front(START_MARK);
		body.push_back(crc[7:0]);
		body.push_back(crc[15:8]);
		total = body.size();
		if (keep > 0 && keep < total) total = keep;
		for (int i = 0; i < total; i++)
			push_byte(body[i], pin && (i == body.size() - 1), res);
	endfunction

	// Mostly good frames with random content, plus noise, bad CRCs,
	// foreign ids and frames cut short.
	function automatic void queue_random_traffic(input int n_bytes);
		int         target;
		int         pick;
		int         lpick;
		logic [7:0] id;
		logic [7:0] len;
		logic [7:0] min_len;
		target = bytes_queued + n_bytes;
		while (bytes_queued < target) begin
			pick = $urandom_range(99);
			id = $urandom_range(1) ? ID_FLOW : ID_DIST;
			min_len = (id == ID_FLOW) ? MIN_LEN_FLOW : MIN_LEN_DIST;
			lpick = $urandom_range(99);
			if (lpick < 70) len = 8'($urandom_range(40));
			else if (lpick < 92) len = min_len - 8'd2 + 8'($urandom_range(4));
			else len = 8'($urandom_range(255, 41));
			if (pick < 70) begin
				queue_frame(id, len, 1'b1, 8'h00, 1'b0, 0, 1'b0, '0);
			end else if (pick < 80) begin
				for (int i = $urandom_range(8, 1); i > 0; i--)
					push_byte(8'($urandom_range(255)), 1'b0, '0);
			end else if (pick < 88) begin
				queue_frame(id, len, 1'b1, 8'h00, 1'b1, 0, 1'b0, '0);
			end else if (pick < 95) begin
				queue_frame(8'($urandom_range(255)), len, 1'b1, 8'h00, 1'b0, 0, 1'b0, '0);
			end else begin
				queue_frame(id, len, 1'b1, 8'h00, 1'b0, $urandom_range(len + 7, 1),
					1'b0, '0);
			end
		end
	endfunction

	function automatic void check_field(input string name, input longint exp_v,
			input longint act_v);
		if (exp_v != act_v) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
			errors++;
		end
	endfunction

	// Sender: the byte on the bus is predicted at the edge it is taken,
	// then the next one is offered unless this cycle idles.
	always @(posedge clk) begin
		mvfd_result_t r;
		bit           got;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				got = parse_byte(s_tdata, r);
				if (in_flight.pinned) results_due_q.push_back(in_flight.pinned_res);
				else if (got) results_due_q.push_back(r);
			end
			if (!s_tvalid || s_tready) begin
				if (rx_bytes_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
					in_flight = rx_bytes_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= in_flight.data;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver: checks each taken result against the oldest one due,
	// stalls at random, and counts out the long hold-off when asked.
	always @(posedge clk) begin
		mvfd_result_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (results_due_q.size() == 0) begin
					$display("%0t: unexpected result, got tdata %h tuser %b",
						$time, m_tdata, m_tuser);
					errors++;
				end else begin
					want = results_due_q.pop_front();
					check_field("message_kind", want.message_kind, m_tuser[0]);
					check_field("fields_updated", want.fields_updated, m_tuser[1]);
					check_field("flow_x", want.flow_x, m_tdata[15:0]);
					check_field("flow_y", want.flow_y, m_tdata[31:16]);
					check_field("flow_quality", want.flow_quality, m_tdata[39:32]);
					check_field("distance_cm", want.distance_cm, m_tdata[55:40]);
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("mavlink_v1_flow_distance_parser_top_test failed");
			$finish;
		end
	end

	// wait until every queued byte has been taken
	task automatic wait_sent;
		while (rx_bytes_q.size() > 0 || s_tvalid) @(negedge clk);
	endtask

	initial begin
		frame_row_t rows[0:14];
		int         drain;

		ph = FP_HUNT;
		p_len = 8'd0;
		p_crc = CRC_INIT;
		p_pos = 8'd0;
		p_id = 8'd0;
		p_crc_lo = 8'd0;
		foreach (kept[i]) kept[i] = 8'd0;
		snap_fx = 16'd0;
		snap_fy = 16'd0;
		snap_q = 8'd0;
		snap_dist = 16'd0;
		in_flight = '0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Hand-built frames. Pinned rows follow one another from reset,
		// so their snapshots chain: all-ones, then zeros, then 0xFE bytes.
		rows = '{
			// zero length distance frame right after reset: nothing updated
			'{ID_DIST, 8'd0,  1'b0, 8'h00, 1'b0, 1'b1,
				mk_result(KIND_DIST, 1'b0, 16'h0000, 16'h0000, 8'h00, 16'h0000)},
			// flow one byte short
			'{ID_FLOW, 8'd25, 1'b0, 8'hFF, 1'b0, 1'b1,
				mk_result(KIND_FLOW, 1'b0, 16'h0000, 16'h0000, 8'h00, 16'h0000)},
			'{ID_FLOW, 8'd26, 1'b0, 8'hFF, 1'b0, 1'b1,
				mk_result(KIND_FLOW, 1'b1, 16'hFFFF, 16'hFFFF, 8'hFF, 16'h0000)},
			'{ID_DIST, 8'd10, 1'b0, 8'hFF, 1'b0, 1'b1,
				mk_result(KIND_DIST, 1'b1, 16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF)},
			'{ID_FLOW, 8'd26, 1'b0, 8'h00, 1'b0, 1'b1,
				mk_result(KIND_FLOW, 1'b1, 16'h0000, 16'h0000, 8'h00, 16'hFFFF)},
			'{ID_DIST, 8'd10, 1'b0, 8'h00, 1'b0, 1'b1,
				mk_result(KIND_DIST, 1'b1, 16'h0000, 16'h0000, 8'h00, 16'h0000)},
			// markers inside the frame, longest payload, bytes past capture
			'{ID_DIST, 8'd255, 1'b0, START_MARK, 1'b0, 1'b1,
				mk_result(KIND_DIST, 1'b1, 16'h0000, 16'h0000, 8'h00, 16'hFEFE)},
			'{ID_FLOW, 8'd40, 1'b0, START_MARK, 1'b0, 1'b1,
				mk_result(KIND_FLOW, 1'b1, 16'hFEFE, 16'hFEFE, 8'hFE, 16'hFEFE)},
			// foreign ids are dropped
			'{8'h00,   8'd5,  1'b0, 8'h00, 1'b0, 1'b0, '0},
			'{8'hFF,   8'd0,  1'b1, 8'h00, 1'b0, 1'b0, '0},
			// corrupted CRC, then good random-filled frames
			'{ID_FLOW, 8'd30, 1'b1, 8'h00, 1'b1, 1'b0, '0},
			'{ID_FLOW, 8'd28, 1'b1, 8'h00, 1'b0, 1'b0, '0},
			'{ID_DIST, 8'd9,  1'b1, 8'h00, 1'b0, 1'b0, '0},
			'{ID_FLOW, 8'd0,  1'b1, 8'h00, 1'b0, 1'b0, '0},
			'{ID_DIST, 8'd12, 1'b1, 8'h00, 1'b0, 1'b0, '0}
		};
		foreach (rows[i])
			queue_frame(rows[i].id, rows[i].len, rows[i].rand_fill, rows[i].fill,
				rows[i].bad_crc, 0, rows[i].pinned, rows[i].res);
		wait_sent();

		// random traffic under each idle pattern
		idle_pct = 0;  stall_pct = 0;  queue_random_traffic(PHASE_BYTES); wait_sent();
		idle_pct = 79; stall_pct = 0;  queue_random_traffic(PHASE_BYTES); wait_sent();
		idle_pct = 0;  stall_pct = 79; queue_random_traffic(PHASE_BYTES); wait_sent();
		idle_pct = 15; stall_pct = 15; queue_random_traffic(PHASE_BYTES); wait_sent();

		// long output hold-off with the sender flat out: a result parks in
		// the output register and the input must back up behind it
		idle_pct = 0;
		stall_pct = 0;
		hold_req = 1'b1;
		for (int i = 0; i < 20; i++)
			queue_frame(ID_DIST, 8'($urandom_range(12)), 1'b1, 8'h00, 1'b0, 0, 1'b0, '0);
		wait_sent();

		drain = 0;
		while (results_due_q.size() > 0 && drain < 5000) begin
			@(negedge clk);
			drain++;
		end
		repeat (20) @(negedge clk);
		if (results_due_q.size() > 0) begin
			$display("%0t: %0d expected results never arrived, next expected %h",
				$time, results_due_q.size(), results_due_q[0]);
			errors++;
		end

		if (errors == 0) begin
			$display("mavlink_v1_flow_distance_parser_top_test passed");
		end else begin
			$display("mavlink_v1_flow_distance_parser_top_test failed");
		end
		$finish;
	end

endmodule
